@@ rtl/dstf_pkg.sv @@
// Shared types, character codes and status codes of the decimal string parser.
package dstf_pkg;

  // Default number of kept fraction digits (the value is scaled by ten to this power).
  localparam int FRACTION_DIGITS_DEF = 4;

  // Length check: character counter width, saturation point and hard length cap.
  localparam int              COUNT_W   = 7;
  localparam logic [COUNT_W-1:0] COUNT_SAT  = 7'd127;
  localparam logic [COUNT_W-1:0] LENGTH_CAP = 7'd64;
  localparam logic [COUNT_W-1:0] MAX_LENGTH_RST = 7'd20;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Largest magnitude that the result may carry.
  localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  // Depth of the queue between the classifier and the accumulator.
  localparam int QUEUE_DEPTH = 2;

  // ASCII codes the classifier looks for.
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_POINT = 8'h2E;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  // Result status codes.
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_TOO_LONG     = 3'd1;
  localparam logic [2:0] ST_SECOND_POINT = 3'd2;
  localparam logic [2:0] ST_BAD_CHAR     = 3'd3;
  localparam logic [2:0] ST_NO_DIGITS    = 3'd4;
  localparam logic [2:0] ST_OVERFLOW     = 3'd5;

  // What the accumulator has to do with one character.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INT_DIGIT,
    OP_FRAC_DIGIT,
    OP_PLUS,
    OP_MINUS,
    OP_ERR_POINT,
    OP_ERR_CHAR
  } dstf_op_e;

  // One classified character as it travels through the queue.
  typedef struct packed {
    dstf_op_e   kind;
    logic [3:0] digit;
    logic       too_long;
    logic       last;
  } dstf_op_t;

  // Power of ten, only ever called with constant arguments at elaboration.
  function automatic longint unsigned pow10(input int n);
    longint unsigned p;
    p = 1;
    for (int k = 0; k < n; k++) begin
      p = p * 10;
    end
    return p;
  endfunction

endpackage

@@ rtl/dstf_in_if.sv @@
// Character channel: one ASCII character and its last marker per word.
interface dstf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] chr;
  logic       last;

  modport source (output valid, output chr, output last, input ready);
  modport sink   (input valid, input chr, input last, output ready);
endinterface

@@ rtl/dstf_out_if.sv @@
// Result channel: scaled signed value and status per word.
interface dstf_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic        [2:0]  status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

@@ rtl/dstf_front.sv @@
// Front end: accepts characters, counts them against the length limit and classifies them.
module dstf_front
  import dstf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  dstf_in_if.sink            in_ch,
  input  logic [COUNT_W-1:0] max_length_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output dstf_op_t           q_word_o
);

  logic [COUNT_W-1:0] count_q, count_d;
  logic               seen_point_q, seen_point_d;
  logic [COUNT_W-1:0] count_inc;
  logic [COUNT_W-1:0] limit;
  logic               is_digit;
  logic               first;
  logic               accept;

  assign in_ch.ready = !q_full_i;
  assign accept      = in_ch.valid && !q_full_i;
  assign q_push_o    = accept;

  assign count_inc = (count_q == COUNT_SAT) ? count_q : count_q + 1'b1;
  assign limit     = (max_length_i > LENGTH_CAP) ? LENGTH_CAP : max_length_i;
  assign is_digit  = (in_ch.chr >= CHR_ZERO) && (in_ch.chr <= CHR_NINE);
  assign first     = (count_q == '0);

  always_comb begin
    q_word_o.digit    = in_ch.chr[3:0];
    q_word_o.too_long = count_inc > limit;
    q_word_o.last     = in_ch.last;
    if (is_digit) begin
      q_word_o.kind = seen_point_q ? OP_FRAC_DIGIT : OP_INT_DIGIT;
    end else if (in_ch.chr == CHR_POINT) begin
      q_word_o.kind = seen_point_q ? OP_ERR_POINT : OP_NONE;
    end else if (first && (in_ch.chr == CHR_PLUS)) begin
      q_word_o.kind = OP_PLUS;
    end else if (first && (in_ch.chr == CHR_MINUS)) begin
      q_word_o.kind = OP_MINUS;
    end else begin
      q_word_o.kind = OP_ERR_CHAR;
    end
  end

  always_comb begin
    count_d      = count_q;
    seen_point_d = seen_point_q;
    if (accept) begin
      if (in_ch.last) begin
        count_d      = '0;
        seen_point_d = 1'b0;
      end else begin
        count_d = count_inc;
        if (!q_word_o.too_long && (in_ch.chr == CHR_POINT)) begin
          seen_point_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      seen_point_q <= 1'b0;
    end else begin
      count_q      <= count_d;
      seen_point_q <= seen_point_d;
    end
  end

endmodule

@@ rtl/dstf_queue.sv @@
// Small register queue that decouples the classifier from the accumulator.
module dstf_queue
  import dstf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  dstf_op_t push_word_i,
  output logic     full_o,
  input  logic     pop_i,
  output dstf_op_t pop_word_o,
  output logic     empty_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  dstf_op_t           slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]     fill_q, fill_d;

  assign full_o     = (fill_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o    = (fill_q == '0);
  assign pop_word_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

@@ rtl/dstf_back.sv @@
// Back end: digit accumulation, final scaling with overflow check, and the result register.
module dstf_back
  import dstf_pkg::*;
#(
  parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dstf_op_t q_word_i,
  input  logic     q_empty_i,
  output logic     q_pop_o,
  dstf_out_if.source out_ch
);

  localparam int FRAC_W  = $clog2(pow10(FRACTION_DIGITS));
  localparam int FC_W    = $clog2(FRACTION_DIGITS + 1);
  localparam int SCALE_W = $clog2(pow10(FRACTION_DIGITS) + 1);
  localparam int PROD_W  = 32 + SCALE_W;
  localparam int FR_W    = FRAC_W + SCALE_W;
  localparam int SUM_W   = 64 + SCALE_W + 1;
  localparam logic [SCALE_W-1:0] SCALE = SCALE_W'(pow10(FRACTION_DIGITS));

  logic pipe_en;

  // Parse state.
  logic [2:0]        err_q, err_d, err_nx;
  logic              neg_q, neg_d, neg_nx;
  logic              digit_q, digit_d, digit_nx;
  logic [63:0]       int_q, int_d, int_nx;
  logic [FRAC_W-1:0] frac_q, frac_d, frac_nx;
  logic [FC_W-1:0]   fc_q, fc_d, fc_nx;
  logic [67:0]       int_step;

  // Snapshot stage.
  logic              valid_a_q;
  logic [2:0]        code_a_q;
  logic              neg_a_q;
  logic [63:0]       int_a_q;
  logic [FRAC_W-1:0] frac_a_q;
  logic [FC_W-1:0]   fc_a_q;

  // Multiply stage.
  logic              valid_b_q;
  logic [2:0]        code_b_q;
  logic              neg_b_q;
  logic [PROD_W-1:0] prod_lo_q;
  logic [PROD_W-1:0] prod_hi_q;
  logic [FR_W-1:0]   frac_prod_q;

  // Sum stage.
  logic              valid_c_q;
  logic [2:0]        code_c_q;
  logic              neg_c_q;
  logic [63:0]       mag_c_q;
  logic [SUM_W-1:0]  total;

  // Result register.
  logic               out_valid_q;
  logic signed [63:0] out_value_q;
  logic [2:0]         out_status_q;

  logic [SCALE_W-1:0] pow_tab [FRACTION_DIGITS+1];

  for (genvar g = 0; g <= FRACTION_DIGITS; g++) begin : g_pow
    assign pow_tab[g] = SCALE_W'(pow10(g));
  end

  // The whole back end moves as one pipeline behind the result register.
  assign pipe_en = !out_valid_q || out_ch.ready;
  assign q_pop_o = !q_empty_i && pipe_en;

  assign int_step = {4'b0, int_q} * 68'd10 + {64'b0, q_word_i.digit};

  always_comb begin
    err_nx   = err_q;
    neg_nx   = neg_q;
    digit_nx = digit_q;
    int_nx   = int_q;
    frac_nx  = frac_q;
    fc_nx    = fc_q;
    if (q_word_i.too_long) begin
      err_nx = ST_TOO_LONG;
    end else if (err_q == ST_OK) begin
      case (q_word_i.kind)
        OP_INT_DIGIT: begin
          digit_nx = 1'b1;
          if (int_step > {4'b0, MAG_MAX}) begin
            err_nx = ST_OVERFLOW;
          end else begin
            int_nx = int_step[63:0];
          end
        end
        OP_FRAC_DIGIT: begin
          digit_nx = 1'b1;
          if (fc_q < FC_W'(FRACTION_DIGITS)) begin
            frac_nx = FRAC_W'(frac_q * 4'd10 + q_word_i.digit);
            fc_nx   = fc_q + 1'b1;
          end
        end
        OP_PLUS:      neg_nx = 1'b0;
        OP_MINUS:     neg_nx = 1'b1;
        OP_ERR_POINT: err_nx = ST_SECOND_POINT;
        OP_ERR_CHAR:  err_nx = ST_BAD_CHAR;
        default:      err_nx = err_q;
      endcase
    end
  end

  always_comb begin
    err_d   = err_q;
    neg_d   = neg_q;
    digit_d = digit_q;
    int_d   = int_q;
    frac_d  = frac_q;
    fc_d    = fc_q;
    if (q_pop_o) begin
      if (q_word_i.last) begin
        err_d   = ST_OK;
        neg_d   = 1'b0;
        digit_d = 1'b0;
        int_d   = '0;
        frac_d  = '0;
        fc_d    = '0;
      end else begin
        err_d   = err_nx;
        neg_d   = neg_nx;
        digit_d = digit_nx;
        int_d   = int_nx;
        frac_d  = frac_nx;
        fc_d    = fc_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q   <= ST_OK;
      neg_q   <= 1'b0;
      digit_q <= 1'b0;
      int_q   <= '0;
      frac_q  <= '0;
      fc_q    <= '0;
    end else begin
      err_q   <= err_d;
      neg_q   <= neg_d;
      digit_q <= digit_d;
      int_q   <= int_d;
      frac_q  <= frac_d;
      fc_q    <= fc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q   <= 1'b0;
      valid_b_q   <= 1'b0;
      valid_c_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      valid_a_q   <= q_pop_o && q_word_i.last;
      valid_b_q   <= valid_a_q;
      valid_c_q   <= valid_b_q;
      out_valid_q <= valid_c_q;
    end
  end

  assign total = SUM_W'({prod_hi_q, 32'b0}) + SUM_W'(prod_lo_q) + SUM_W'(frac_prod_q);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      // Snapshot of the finished string; a clean string without digits is reported here.
      code_a_q <= (err_nx == ST_OK && !digit_nx) ? ST_NO_DIGITS : err_nx;
      neg_a_q  <= neg_nx;
      int_a_q  <= int_nx;
      frac_a_q <= frac_nx;
      fc_a_q   <= fc_nx;

      code_b_q    <= code_a_q;
      neg_b_q     <= neg_a_q;
      prod_lo_q   <= {{SCALE_W{1'b0}}, int_a_q[31:0]} * {32'b0, SCALE};
      prod_hi_q   <= {{SCALE_W{1'b0}}, int_a_q[63:32]} * {32'b0, SCALE};
      frac_prod_q <= {{SCALE_W{1'b0}}, frac_a_q} *
                     {{FRAC_W{1'b0}}, pow_tab[FC_W'(FRACTION_DIGITS) - fc_a_q]};

      code_c_q <= (code_b_q == ST_OK && total > SUM_W'(MAG_MAX)) ? ST_OVERFLOW : code_b_q;
      neg_c_q  <= neg_b_q;
      mag_c_q  <= total[63:0];

      out_status_q <= code_c_q;
      if (code_c_q != ST_OK) begin
        out_value_q <= '0;
      end else if (neg_c_q) begin
        out_value_q <= -$signed(mag_c_q);
      end else begin
        out_value_q <= $signed(mag_c_q);
      end
    end
  end

  assign out_ch.valid  = out_valid_q;
  assign out_ch.value  = out_value_q;
  assign out_ch.status = out_status_q;

endmodule

@@ rtl/decimal_string_to_fixed_core.sv @@
// Top level of the ASCII decimal to fixed-point parser.
//
//   channel   direction  word contents                  handshake
//   in_ch     in         chr[7:0], last                 valid / ready
//   out_ch    out        value[63:0] signed, status[2:0] valid / ready
//   APB       in         max_length at byte address 0   psel / penable / pwrite
//
// One character word is accepted per cycle while the two-word queue has room;
// the accumulator's multiply by ten and add per character sets that rate.
// Once a string's last character is accepted, its result goes through the queue,
// snapshot, scale multiply, sum with overflow compare, then the result register.
// Reset (rst_ni low) clears all parse state and sets max_length to 20.
// A stalled result word freezes the back end; the queue fills and ready drops.
module decimal_string_to_fixed_core
  import dstf_pkg::*;
#(
  parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  dstf_in_if.sink            in_ch,
  dstf_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // Register index sits in paddr[2]; only index zero exists.
  localparam logic REG_MAX_LENGTH = 1'b0;

  logic [COUNT_W-1:0] max_length_q, max_length_d;
  logic               cfg_write;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  dstf_op_t           q_push_word;
  dstf_op_t           q_pop_word;

  // Configuration register. Writes land on the access cycle of an APB write.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MAX_LENGTH);
  assign prdata    = (paddr[2] == REG_MAX_LENGTH) ? PDATA_W'(max_length_q) : '0;

  always_comb begin
    max_length_d = max_length_q;
    if (cfg_write) begin
      max_length_d = pwdata[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= MAX_LENGTH_RST;
    end else begin
      max_length_q <= max_length_d;
    end
  end

  // The front end classifies each character and checks the length limit.
  dstf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .max_length_i (max_length_q),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_word_o     (q_push_word)
  );

  // The queue lets the front keep accepting while the result side is stalled.
  dstf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_word_i (q_push_word),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_word_o  (q_pop_word),
    .empty_o     (q_empty)
  );

  // The back end accumulates digits and scales the finished number.
  dstf_back #(
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_word_i  (q_pop_word),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .out_ch    (out_ch)
  );

`ifndef ASSERT_OFF
  // Any error status carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.status != ST_OK) |-> (out_ch.value == '0))
    else $error("error result with nonzero value");

  // Status codes stay within the defined set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> (out_ch.status <= ST_OVERFLOW))
    else $error("undefined status code");

  // A configuration write takes effect on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_write |=> (max_length_q == $past(pwdata[COUNT_W-1:0])))
    else $error("max_length write lost");

  // The queue is never pushed when full nor popped when empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full) && !(q_pop && q_empty))
    else $error("queue misuse");
`endif

endmodule

@@ test/decimal_string_to_fixed_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the ASCII decimal string to fixed-point parser.
module decimal_string_to_fixed_core_test;
  import dstf_pkg::*;

  // The block runs with its default number of fraction digits.
  localparam int FRAC_DIGITS = FRACTION_DIGITS_DEF;

  // max_length is the only register, at byte address zero.
  localparam logic [PADDR_W-1:0] REG_MAX_LENGTH = '0;

  // The run is tiny next to this.
  localparam int CYCLE_LIMIT = 400000;

  // Strings that end in no result do not exist here, but we still let the
  // pipe run empty.
  localparam int DRAIN_CYCLES = 12;

  // Characters per phase of max_length. Nine phases give about 1050 words.
  localparam int PHASE_CHARS = 117;
  localparam int N_PHASES    = 9;
  localparam int DIR_ROWS    = 23;

  typedef struct {
    logic signed [63:0] value;
    logic        [2:0]  status;
  } result_t;

  // One row of the directed table. Where typed is set, the expected result is
  // given in the row itself; otherwise the predictor supplies it.
  typedef struct {
    logic [7:0]         chr;
    bit                 last;
    bit                 typed;
    logic signed [63:0] value;
    logic        [2:0]  status;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  dstf_in_if  in_ch ();
  dstf_out_if out_ch ();

  decimal_string_to_fixed_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Results that the parser owes us, oldest first.
  result_t due_results [$];
  int unsigned mismatches;
  int unsigned cycles;
  bit gaps_on;
  int unsigned stall_left;

  // The string that is about to be sent, one character per entry.
  logic [7:0] spell [$];

  string boundary_nums [6] = '{
    "9223372036854775807",
    "9223372036854775808",
    "99999999999999999999",
    "922337203685477.5807",
    "922337203685477.5808",
    "922337203685477.58079999"
  };

  stim_row_t dir_rows [DIR_ROWS];

  // Our own copy of the parse state and of max_length.
  logic [6:0]  max_len;
  logic [6:0]  n_chars;
  bit          is_neg;
  bit          got_point;
  bit          got_digit;
  logic [2:0]  first_err;
  logic [63:0] int_part;
  logic [31:0] frac_part;
  int unsigned frac_kept;

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [63:0] ten_pow(input int unsigned n);
    logic [63:0] p;
    p = 64'd1;
    for (int unsigned k = 0; k < n; k++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  function automatic void clear_number();
    n_chars   = '0;
    is_neg    = 1'b0;
    got_point = 1'b0;
    got_digit = 1'b0;
    first_err = ST_OK;
    int_part  = '0;
    frac_part = '0;
    frac_kept = 0;
  endfunction

  // Folds one accepted character into the parse state. On the last character
  // of a string it returns 1 with the result that the parser must give.
  function automatic bit parse_char(input logic [7:0] c, input bit fin,
                                    output result_t res);
    bit          first;
    logic [6:0]  lim;
    logic [63:0] d;
    logic [63:0] frac;
    logic [63:0] mag;
    logic [2:0]  code;
    first = (n_chars == 0);
    lim = (max_len > LENGTH_CAP) ? LENGTH_CAP : max_len;
    if (n_chars < COUNT_SAT) n_chars = n_chars + 7'd1;

    // Too long wins over everything; otherwise the first error sticks and
    // later characters are only counted.
    if (n_chars > lim) begin
      first_err = ST_TOO_LONG;
    end else if (first_err == ST_OK) begin
      if (c >= CHR_ZERO && c <= CHR_NINE) begin
        d = 64'(c - CHR_ZERO);
        got_digit = 1'b1;
        if (!got_point) begin
          if (int_part > (MAG_MAX - d) / 64'd10) begin
            first_err = ST_OVERFLOW;
          end else begin
            int_part = int_part * 64'd10 + d;
          end
        end else if (frac_kept < FRAC_DIGITS) begin
          // Digits past the kept ones are dropped, not rounded.
          frac_part = frac_part * 32'd10 + 32'(d);
          frac_kept++;
        end
      end else if (c == CHR_POINT) begin
        if (got_point) first_err = ST_SECOND_POINT;
        else got_point = 1'b1;
      end else if (first && (c == CHR_PLUS || c == CHR_MINUS)) begin
        is_neg = (c == CHR_MINUS);
      end else begin
        first_err = ST_BAD_CHAR;
      end
    end

    res.value  = '0;
    res.status = ST_OK;
    if (!fin) return 1'b0;

    code = first_err;
    if (code == ST_OK && !got_digit) code = ST_NO_DIGITS;
    mag = '0;
    if (code == ST_OK) begin
      // Second overflow check: the scaled magnitude must still fit.
      frac = 64'(frac_part) * ten_pow(FRAC_DIGITS - frac_kept);
      if (int_part > (MAG_MAX - frac) / ten_pow(FRAC_DIGITS)) begin
        code = ST_OVERFLOW;
      end else begin
        mag = int_part * ten_pow(FRAC_DIGITS) + frac;
      end
    end
    res.status = code;
    if (code == ST_OK) res.value = is_neg ? (64'd0 - mag) : mag;
    clear_number();
    return 1'b1;
  endfunction

  // Offers one character word, optionally after a random gap, and waits for
  // the handshake. Prediction happens at the acceptance edge.
  task automatic send_word(input logic [7:0] c, input bit fin, input bit typed,
                           input result_t typed_res);
    result_t res;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.chr   <= c;
    in_ch.last  <= fin;
    do @(posedge clk_i); while (!in_ch.ready);
    if (parse_char(c, fin, res)) begin
      if (typed && (res.value != typed_res.value || res.status != typed_res.status)) begin
        flag_mismatch($sformatf("table row expects %0d/%0d, predictor gives %0d/%0d",
                                typed_res.value, typed_res.status, res.value, res.status));
      end
      due_results.push_back(typed ? typed_res : res);
    end
  endtask

  task automatic send_string();
    result_t none;
    none.value  = '0;
    none.status = ST_OK;
    foreach (spell[i]) send_word(spell[i], i == spell.size() - 1, 1'b0, none);
  endtask

  task automatic add_digits(input int unsigned n);
    repeat (n) spell.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // A well-formed number: optional sign, digits, optional point and fraction.
  // Long integer parts are there to hit the overflow at the final scaling.
  task automatic build_number();
    int unsigned n_int;
    int unsigned n_frac;
    bit          point;
    spell.delete();
    case ($urandom_range(0, 3))
      0: spell.push_back(CHR_MINUS);
      1: spell.push_back(CHR_PLUS);
      default: ;
    endcase
    n_int  = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 18) : $urandom_range(0, 6);
    point  = $urandom_range(0, 1);
    n_frac = point ? $urandom_range(0, 7) : 0;
    if (n_int == 0 && n_frac == 0) n_int = 1;
    add_digits(n_int);
    if (point) spell.push_back(CHR_POINT);
    add_digits(n_frac);
  endtask

  // Picks the next string. Most are well-formed numbers that fit the current
  // length limit; the rest are boundary magnitudes, broken numbers, noise and
  // strings that run past the limit.
  task automatic make_string();
    int unsigned pick;
    int unsigned lim_now;
    int unsigned pos;
    int unsigned goal;
    logic [7:0]  odd;
    string       s;
    pick    = $urandom_range(0, 99);
    lim_now = (max_len > LENGTH_CAP) ? LENGTH_CAP : max_len;
    if (pick < 60) begin
      build_number();
      while (spell.size() > lim_now && spell.size() > 1) void'(spell.pop_front());
    end else if (pick < 70) begin
      spell.delete();
      s = boundary_nums[$urandom_range(0, 5)];
      if ($urandom_range(0, 1)) spell.push_back(CHR_MINUS);
      for (int i = 0; i < s.len(); i++) spell.push_back(s[i]);
    end else if (pick < 85) begin
      build_number();
      case ($urandom_range(0, 3))
        0: odd = CHR_POINT;
        1: odd = CHR_PLUS;
        2: odd = CHR_MINUS;
        default: odd = 8'($urandom_range(0, 255));
      endcase
      pos = $urandom_range(0, spell.size() - 1);
      if ($urandom_range(0, 1)) spell[pos] = odd;
      else spell.insert(pos, odd);
    end else if (pick < 95) begin
      spell.delete();
      repeat ($urandom_range(1, 6)) spell.push_back(8'($urandom_range(0, 255)));
    end else begin
      build_number();
      // Now and then run far past the character counter's saturation point.
      goal = ($urandom_range(0, 4) == 0) ? 130 : lim_now + 1 + $urandom_range(0, 2);
      while (spell.size() < goal) add_digits(1);
    end
  endtask

  // Waits until every owed result has come, then lets the pipe run empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write of max_length with random upper data bits, then a read back.
  task automatic write_max_length(input logic [6:0] val);
    logic [PDATA_W-1:0] word;
    word      = PDATA_W'($urandom());
    word[6:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_MAX_LENGTH;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    max_len = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[6:0] !== val) begin
      flag_mismatch($sformatf("max_length reads %0d, written %0d", prdata[6:0], val));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result side: random stall bursts on ready, and every accepted word is
  // compared field by field with the oldest owed result.
  always @(posedge clk_i) begin
    result_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected word %0d/%0d", out_ch.value, out_ch.status));
      end else begin
        want = due_results.pop_front();
        if (out_ch.status !== want.status) begin
          flag_mismatch($sformatf("status %0d, expected %0d", out_ch.status, want.status));
        end
        if (out_ch.value !== want.value) begin
          flag_mismatch($sformatf("value %0d, expected %0d", out_ch.value, want.value));
        end
      end
    end
    if (gaps_on && stall_left == 0 && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 15);
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("decimal_string_to_fixed_core_test NOT OK");
      $finish;
    end
  end

  initial begin
    int          lengths [N_PHASES];
    int unsigned sent;
    result_t     typed_res;

    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_ch.valid  = 1'b0;
    in_ch.chr    = '0;
    in_ch.last   = 1'b0;
    out_ch.ready = 1'b0;
    mismatches   = 0;
    cycles       = 0;
    stall_left   = 0;
    gaps_on      = 1'b1;
    max_len      = MAX_LENGTH_RST;
    clear_number();

    // Phase settings of max_length: reset value first, then the cap of 64, the
    // extremes (1 and 0), values above the cap, 33, a random one, and back to 20.
    lengths = '{20, 64, 1, 0, 127, 100, 33, -1, 20};

    // Directed table: single-character extremes, lone sign and lone point,
    // bad bytes, a second point, a sign out of place, fraction truncation
    // and a negative zero integer part.
    dir_rows = '{
      '{"7",   1'b1, 1'b1, 64'sd70000, ST_OK},
      '{"0",   1'b1, 1'b1, 64'sd0,     ST_OK},
      '{"-",   1'b1, 1'b1, 64'sd0,     ST_NO_DIGITS},
      '{".",   1'b1, 1'b1, 64'sd0,     ST_NO_DIGITS},
      '{8'h00, 1'b1, 1'b1, 64'sd0,     ST_BAD_CHAR},
      '{8'hFF, 1'b1, 1'b1, 64'sd0,     ST_BAD_CHAR},
      '{"+",   1'b0, 1'b0, 64'sd0,     ST_OK},
      '{"5",   1'b1, 1'b0, 64'sd0,     ST_OK},
      '{".",   1'b0, 1'b0, 64'sd0,     ST_OK},
      '{".",   1'b1, 1'b1, 64'sd0,     ST_SECOND_POINT},
      '{"1",   1'b0, 1'b0, 64'sd0,     ST_OK},
      '{"-",   1'b1, 1'b1, 64'sd0,     ST_BAD_CHAR},
      '{"-",   1'b0, 1'b0, 64'sd0,     ST_OK},
      '{".",   1'b0, 1'b0, 64'sd0,     ST_OK},
      '{"1",   1'b0, 1'b0, 64'sd0,     ST_OK},
      '{"2",   1'b0, 1'b0, 64'sd0,     ST_OK},
      '{"3",   1'b0, 1'b0, 64'sd0,     ST_OK},
      '{"4",   1'b0, 1'b0, 64'sd0,     ST_OK},
      '{"5",   1'b1, 1'b0, 64'sd0,     ST_OK},
      '{"-",   1'b0, 1'b0, 64'sd0,     ST_OK},
      '{"0",   1'b0, 1'b0, 64'sd0,     ST_OK},
      '{".",   1'b0, 1'b0, 64'sd0,     ST_OK},
      '{"5",   1'b1, 1'b0, 64'sd0,     ST_OK}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      typed_res.value  = dir_rows[i].value;
      typed_res.status = dir_rows[i].status;
      send_word(dir_rows[i].chr, dir_rows[i].last, dir_rows[i].typed, typed_res);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      // The register only changes while the parser is idle. The first phase
      // keeps the reset value.
      if (p > 0) begin
        settle();
        write_max_length(lengths[p] < 0 ? 7'($urandom_range(2, 63)) : 7'(lengths[p]));
      end
      // The last phase runs with no gaps and no stalls at all.
      gaps_on = (p != N_PHASES - 1);
      sent = 0;
      while (sent < PHASE_CHARS) begin
        make_string();
        send_string();
        sent += spell.size();
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("decimal_string_to_fixed_core_test OK");
    end else begin
      $display("decimal_string_to_fixed_core_test NOT OK");
    end
    $finish;
  end

endmodule
